[hw/rtl/tsdmx_pkg.sv]
`default_nettype none

package tsdmx_pkg;

  // Default sizes of the packet frame and of the per-PID table.
  localparam int DEF_PACKET_BYTES = 188;
  localparam int DEF_PID_ENTRIES  = 8192;

  localparam logic [7:0] SYNC_BYTE = 8'h47;

  // Result kinds.
  localparam logic [1:0] KIND_SYNC = 2'd0;
  localparam logic [1:0] KIND_HDR  = 2'd1;
  localparam logic [1:0] KIND_PAY  = 2'd2;

  // Header status codes.
  localparam logic [2:0] ST_NEW       = 3'd0;
  localparam logic [2:0] ST_CONT      = 3'd1;
  localparam logic [2:0] ST_REPEAT    = 3'd2;
  localparam logic [2:0] ST_AWAIT     = 3'd3;
  localparam logic [2:0] ST_ERROR     = 3'd4;
  localparam logic [2:0] ST_SCRAMBLED = 3'd5;
  localparam logic [2:0] ST_PID_ZERO  = 3'd6;
  localparam logic [2:0] ST_NO_PAY    = 3'd7;

  // Bit positions inside one table entry: counter in bits 3..0.
  localparam int ENT_VALID = 4;
  localparam int ENT_HAS   = 5;

  // One result transaction.
  typedef struct packed {
    logic [1:0]  result_kind;
    logic [2:0]  status;
    logic [12:0] packet_id;
    logic        discontinuity;
    logic [3:0]  counter_gap;
    logic [15:0] dropped_bytes;
    logic [7:0]  payload_byte;
    logic        to_previous;
    logic        section_start;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

[hw/rtl/ts_packet_demux_cc_check.sv]
`default_nettype none

// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_stall    in_stream_byte
// out_      output     out_valid/out_stall  result_kind .. last
//
// One byte is taken per cycle while in_stall is low. The PID entry is read
// from the table memory on the third header byte and written back on the
// fourth header byte and on forwarded payload bytes; reads and writes never
// share a cycle. After reset a clearing pass writes every table entry, during
// which in_stall is high. An output register and a skid register keep input
// flowing while a result waits; outside the clearing pass, in_stall rises
// only when both are occupied.
module ts_packet_demux_cc_check #(
  parameter int PACKET_BYTES = tsdmx_pkg::DEF_PACKET_BYTES,
  parameter int PID_ENTRIES  = tsdmx_pkg::DEF_PID_ENTRIES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_stream_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_result_kind,
  output logic [2:0]       out_status,
  output logic [12:0]      out_packet_id,
  output logic             out_discontinuity,
  output logic [3:0]       out_counter_gap,
  output logic [15:0]      out_dropped_bytes,
  output logic [7:0]       out_payload_byte,
  output logic             out_to_previous,
  output logic             out_section_start,
  output logic             out_last
);
  import tsdmx_pkg::*;

  localparam int PosW = $clog2(PACKET_BYTES);
  localparam int IdxW = $clog2(PID_ENTRIES);
  localparam logic [PosW-1:0] POS_LAST = PosW'(PACKET_BYTES - 1);
  localparam logic [IdxW-1:0] IDX_LAST = IdxW'(PID_ENTRIES - 1);

  // Payload modes.
  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_PREFIX = 2'd1;
  localparam logic [1:0] MODE_PTR    = 2'd2;
  localparam logic [1:0] MODE_FWD    = 2'd3;

  // Framing and header state.
  logic            in_sync_r, in_sync_nxt;
  logic [PosW-1:0] pos_r, pos_nxt;
  logic [15:0]     drop_r, drop_nxt;
  logic [23:0]     hdr_r, hdr_nxt;
  logic [1:0]      mode_r, mode_nxt;
  logic [7:0]      skip_r, skip_nxt;
  logic [7:0]      ptr_r, ptr_nxt;
  logic            af_pend_r, af_pend_nxt;
  logic            ptr_pend_r, ptr_pend_nxt;
  logic            start_pend_r, start_pend_nxt;
  logic            prev_has_r, prev_has_nxt;
  logic [5:0]      entry_r, entry_nxt;
  logic [IdxW-1:0] idx_r, idx_nxt;

  // Clearing pass.
  logic            clr_active_r;
  logic [IdxW-1:0] clr_addr_r;

  // Table memory ports.
  logic [5:0]      mem [PID_ENTRIES];
  logic [5:0]      rd_data_r;
  logic            rd_en;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  logic [5:0]      wr_data;

  // Output register and skid stage.
  res_t res;
  logic res_vld;
  res_t out_r, skid_r;
  logic out_valid_r, skid_valid_r;

  logic in_acc;
  logic out_take;

  assign in_stall = clr_active_r || skid_valid_r;
  assign in_acc   = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;

  // PID modulo table size from two constant tables and one correction.
  logic [IdxW-1:0] hi_mod [32];
  logic [IdxW-1:0] lo_mod [256];
  logic [IdxW:0]   idx_sum;
  logic [IdxW-1:0] idx_calc;

  for (genvar g = 0; g < 32; g++) begin : g_hi
    assign hi_mod[g] = IdxW'((g * 256) % PID_ENTRIES);
  end
  for (genvar g = 0; g < 256; g++) begin : g_lo
    assign lo_mod[g] = IdxW'(g % PID_ENTRIES);
  end

  always_comb begin
    idx_sum = {1'b0, hi_mod[hdr_r[4:0]]} + {1'b0, lo_mod[in_stream_byte]};
    if (idx_sum >= (IdxW+1)'(PID_ENTRIES)) begin
      idx_calc = IdxW'(idx_sum - (IdxW+1)'(PID_ENTRIES));
    end else begin
      idx_calc = IdxW'(idx_sum);
    end
  end

  // Per-byte processing: framing, header decode and payload steering.
  always_comb begin
    logic [23:0] h;
    logic [5:0]  ent;
    logic [2:0]  st;
    logic [3:0]  nxt_cc;
    logic        af_v;
    logic        ptrp_v;
    logic [7:0]  skip_v;
    logic [7:0]  ptr_v;

    in_sync_nxt    = in_sync_r;
    pos_nxt        = pos_r;
    drop_nxt       = drop_r;
    hdr_nxt        = hdr_r;
    mode_nxt       = mode_r;
    skip_nxt       = skip_r;
    ptr_nxt        = ptr_r;
    af_pend_nxt    = af_pend_r;
    ptr_pend_nxt   = ptr_pend_r;
    start_pend_nxt = start_pend_r;
    prev_has_nxt   = prev_has_r;
    entry_nxt      = entry_r;
    idx_nxt        = idx_r;
    res            = '0;
    res_vld        = 1'b0;
    rd_en          = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = idx_r;
    wr_data        = entry_r;
    h              = {hdr_r[15:0], in_stream_byte};
    ent            = rd_data_r;
    st             = ST_AWAIT;
    nxt_cc         = ent[3:0] + 4'd1;
    af_v           = af_pend_r;
    ptrp_v         = ptr_pend_r;
    skip_v         = skip_r;
    ptr_v          = ptr_r;

    if (clr_active_r) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r;
      wr_data = '0;
    end else if (in_acc) begin
      if (!in_sync_r) begin
        // Hunting for the sync byte.
        if (in_stream_byte != SYNC_BYTE) begin
          if (drop_r != 16'hffff) drop_nxt = drop_r + 16'd1;
        end else begin
          in_sync_nxt = 1'b1;
          pos_nxt     = PosW'(1);
          hdr_nxt     = '0;
          mode_nxt    = MODE_NONE;
          if (drop_r != '0) begin
            res_vld           = 1'b1;
            res.result_kind   = KIND_SYNC;
            res.dropped_bytes = drop_r;
            drop_nxt          = '0;
          end
        end
      end else begin
        if (pos_r <= PosW'(3)) begin
          hdr_nxt = h;
          // Third header byte completes the PID: fetch its entry.
          if (pos_r == PosW'(2)) begin
            rd_en   = 1'b1;
            idx_nxt = idx_calc;
          end
          // Fourth header byte: decode, check continuity, update entry.
          if (pos_r == PosW'(3)) begin
            mode_nxt       = MODE_NONE;
            skip_nxt       = '0;
            ptr_nxt        = '0;
            af_pend_nxt    = 1'b0;
            ptr_pend_nxt   = 1'b0;
            start_pend_nxt = 1'b0;
            prev_has_nxt   = 1'b0;
            res_vld         = 1'b1;
            res.result_kind = KIND_HDR;
            res.packet_id   = h[20:8];
            priority if (h[23]) begin
              st = ST_ERROR;
            end else if (h[7:6] != 2'd0) begin
              st = ST_SCRAMBLED;
            end else if (h[20:8] == '0) begin
              st = ST_PID_ZERO;
            end else if (!h[4]) begin
              st = ST_NO_PAY;
            end else if (h[22]) begin
              st             = ST_NEW;
              prev_has_nxt   = ent[ENT_HAS];
              wr_en          = 1'b1;
              wr_data        = {2'b01, h[3:0]};
              ptr_pend_nxt   = 1'b1;
              start_pend_nxt = 1'b1;
            end else if (ent[ENT_VALID]) begin
              res.discontinuity = (h[3:0] != nxt_cc);
              res.counter_gap   = h[3:0] - nxt_cc;
              if (h[3:0] == ent[3:0]) begin
                st = ST_REPEAT;
              end else begin
                st      = ST_CONT;
                wr_en   = 1'b1;
                wr_data = {ent[ENT_HAS], 1'b1, h[3:0]};
              end
            end else begin
              st = ST_AWAIT;
            end
            entry_nxt  = wr_data;
            res.status = st;
            if (st == ST_NEW || st == ST_CONT) begin
              af_pend_nxt = h[5];
              mode_nxt    = MODE_PREFIX;
              if (!h[5] && st == ST_CONT) mode_nxt = MODE_FWD;
            end
          end
        end else begin
          unique case (mode_r)
            MODE_PREFIX: begin
              // Adaptation length, its skipped bytes, then the pointer byte.
              if (af_pend_r) begin
                skip_v = in_stream_byte;
                af_v   = 1'b0;
              end else if (skip_r != '0) begin
                skip_v = skip_r - 8'd1;
              end else if (ptr_pend_r) begin
                ptr_v  = in_stream_byte;
                ptrp_v = 1'b0;
              end
              af_pend_nxt  = af_v;
              skip_nxt     = skip_v;
              ptr_nxt      = ptr_v;
              ptr_pend_nxt = ptrp_v;
              if (!af_v && skip_v == '0 && !ptrp_v) begin
                mode_nxt = (ptr_v != '0) ? MODE_PTR : MODE_FWD;
              end
            end
            MODE_PTR: begin
              // Bytes that close the previous section.
              ptr_nxt = ptr_r - 8'd1;
              if (ptr_r == 8'd1) mode_nxt = MODE_FWD;
              if (prev_has_r) begin
                res_vld           = 1'b1;
                res.result_kind   = KIND_PAY;
                res.packet_id     = hdr_r[20:8];
                res.payload_byte  = in_stream_byte;
                res.to_previous   = 1'b1;
                res.last          = (pos_r >= POS_LAST);
              end
            end
            MODE_FWD: begin
              // Forwarded byte: mark the PID as holding data.
              wr_en             = 1'b1;
              wr_data           = entry_r | 6'h20;
              entry_nxt         = wr_data;
              res_vld           = 1'b1;
              res.result_kind   = KIND_PAY;
              res.packet_id     = hdr_r[20:8];
              res.payload_byte  = in_stream_byte;
              res.section_start = start_pend_r;
              res.last          = (pos_r >= POS_LAST);
              start_pend_nxt    = 1'b0;
            end
            default: begin
            end
          endcase
        end
        // Packet end returns to hunting.
        if (pos_r >= POS_LAST) begin
          in_sync_nxt = 1'b0;
          pos_nxt     = '0;
          mode_nxt    = MODE_NONE;
        end else begin
          pos_nxt = pos_r + PosW'(1);
        end
      end
    end
  end

  // Table memory with registered read.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[idx_calc];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_sync_r    <= 1'b0;
      pos_r        <= '0;
      drop_r       <= '0;
      hdr_r        <= '0;
      mode_r       <= MODE_NONE;
      skip_r       <= '0;
      ptr_r        <= '0;
      af_pend_r    <= 1'b0;
      ptr_pend_r   <= 1'b0;
      start_pend_r <= 1'b0;
      prev_has_r   <= 1'b0;
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else begin
      in_sync_r    <= in_sync_nxt;
      pos_r        <= pos_nxt;
      drop_r       <= drop_nxt;
      hdr_r        <= hdr_nxt;
      mode_r       <= mode_nxt;
      skip_r       <= skip_nxt;
      ptr_r        <= ptr_nxt;
      af_pend_r    <= af_pend_nxt;
      ptr_pend_r   <= ptr_pend_nxt;
      start_pend_r <= start_pend_nxt;
      prev_has_r   <= prev_has_nxt;
      if (clr_active_r) begin
        clr_addr_r <= clr_addr_r + IdxW'(1);
        if (clr_addr_r == IDX_LAST) clr_active_r <= 1'b0;
      end
    end
  end

  // Entry copy and index of the current packet.
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    idx_r   <= idx_nxt;
  end

  // Output register with skid stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (res_vld) begin
      if (!out_valid_r || out_take) begin
        out_r       <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_kind   = out_r.result_kind;
  assign out_status        = out_r.status;
  assign out_packet_id     = out_r.packet_id;
  assign out_discontinuity = out_r.discontinuity;
  assign out_counter_gap   = out_r.counter_gap;
  assign out_dropped_bytes = out_r.dropped_bytes;
  assign out_payload_byte  = out_r.payload_byte;
  assign out_to_previous   = out_r.to_previous;
  assign out_section_start = out_r.section_start;
  assign out_last          = out_r.last;

  // The skid stage only fills behind an occupied output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds a transaction with the output register empty");

  // A table read and a table write never fall in the same cycle.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !wr_en)
    else $error("table read and write in the same cycle");

  // Payload steering happens only inside a framed packet.
  a_mode_in_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != MODE_NONE) |-> in_sync_r)
    else $error("payload mode active while hunting for sync");

endmodule

`default_nettype wire

[verif/tb_ts_packet_demux_cc_check.sv]
`timescale 1ns / 100ps

module tb_ts_packet_demux_cc_check;
  import tsdmx_pkg::*;

  localparam int PKT      = DEF_PACKET_BYTES;
  localparam int PIDS     = DEF_PID_ENTRIES;
  localparam int MAX_IDLE = 30;

  typedef enum logic [1:0] {PM_NONE, PM_PREFIX, PM_POINTER, PM_FORWARD} pay_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_stream_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_result_kind;
  logic [2:0]  out_status;
  logic [12:0] out_packet_id;
  logic        out_discontinuity;
  logic [3:0]  out_counter_gap;
  logic [15:0] out_dropped_bytes;
  logic [7:0]  out_payload_byte;
  logic        out_to_previous;
  logic        out_section_start;
  logic        out_last;

  ts_packet_demux_cc_check #(
    .PACKET_BYTES(PKT),
    .PID_ENTRIES (PIDS)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_stream_byte   (in_stream_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_status       (out_status),
    .out_packet_id    (out_packet_id),
    .out_discontinuity(out_discontinuity),
    .out_counter_gap  (out_counter_gap),
    .out_dropped_bytes(out_dropped_bytes),
    .out_payload_byte (out_payload_byte),
    .out_to_previous  (out_to_previous),
    .out_section_start(out_section_start),
    .out_last         (out_last)
  );

  always #10 clk = ~clk;

  // Pending stream bytes and the results predicted for accepted bytes.
  logic [7:0] ts_bytes[$];
  res_t       predicted_results[$];
  int         mismatch_count = 0;
  longint     cycle_count = 0;
  longint     cycle_limit = 64'd1 << 40;

  // Predictor state: sync hunt, packet framing, payload prefix and the PID table.
  logic        locked = 1'b0;
  int          pkt_pos = 0;
  logic [15:0] drop_cnt = '0;
  logic [23:0] hdr = '0;
  pay_mode_t   pay_mode = PM_NONE;
  logic [7:0]  skip_cnt = '0;
  logic [7:0]  ptr_cnt = '0;
  logic        af_wait = 1'b0;
  logic        ptr_wait = 1'b0;
  logic        start_wait = 1'b0;
  logic        prev_data = 1'b0;
  logic [5:0]  cc_table[PIDS];

  initial begin
    for (int i = 0; i < PIDS; i++) cc_table[i] = '0;
  end

  // Once the adaptation length, its skip and the pointer byte are consumed,
  // the packet moves on to the pointer span or straight to forwarding.
  function automatic void settle_prefix();
    if (!af_wait && skip_cnt == 0 && !ptr_wait)
      pay_mode = (ptr_cnt != 0) ? PM_POINTER : PM_FORWARD;
  endfunction

  // Advances the predicted demux by one accepted byte and queues any result.
  task automatic demux_step(input logic [7:0] b);
    res_t        r;
    int          pos;
    logic        last_b;
    logic [12:0] pid;
    logic [3:0]  cc;
    logic [3:0]  last_cc;
    logic [3:0]  nxt;
    logic [5:0]  ent;
    logic [5:0]  ent_new;
    int          idx;
    r = '0;
    if (!locked) begin
      if (b != SYNC_BYTE) begin
        if (drop_cnt != 16'hffff) drop_cnt++;
      end else begin
        locked = 1'b1;
        pkt_pos = 1;
        hdr = '0;
        pay_mode = PM_NONE;
        if (drop_cnt != 0) begin
          r.result_kind = KIND_SYNC;
          r.dropped_bytes = drop_cnt;
          drop_cnt = '0;
          predicted_results.push_back(r);
        end
      end
    end else begin
      pos = pkt_pos;
      last_b = (pos + 1 >= PKT);
      pid = hdr[20:8];
      idx = int'(pid) % PIDS;
      if (pos <= 3) begin
        hdr = {hdr[15:0], b};
        if (pos == 3) begin
          // Header decode: status precedence, then the continuity check.
          pid = hdr[20:8];
          cc = hdr[3:0];
          idx = int'(pid) % PIDS;
          ent = cc_table[idx];
          r.result_kind = KIND_HDR;
          r.packet_id = pid;
          pay_mode = PM_NONE;
          skip_cnt = '0;
          ptr_cnt = '0;
          af_wait = 1'b0;
          ptr_wait = 1'b0;
          start_wait = 1'b0;
          prev_data = 1'b0;
          if (hdr[23]) r.status = ST_ERROR;
          else if (hdr[7:6] != 2'b00) r.status = ST_SCRAMBLED;
          else if (pid == 0) r.status = ST_PID_ZERO;
          else if (!hdr[4]) r.status = ST_NO_PAY;
          else if (hdr[22]) begin
            r.status = ST_NEW;
            prev_data = ent[ENT_HAS];
            ent_new = {2'b00, cc};
            ent_new[ENT_VALID] = 1'b1;
            cc_table[idx] = ent_new;
            ptr_wait = 1'b1;
            start_wait = 1'b1;
          end else if (ent[ENT_VALID]) begin
            last_cc = ent[3:0];
            nxt = last_cc + 4'd1;
            r.discontinuity = (cc != nxt);
            r.counter_gap = cc - nxt;
            if (cc == last_cc) r.status = ST_REPEAT;
            else begin
              r.status = ST_CONT;
              ent_new = {2'b00, cc};
              ent_new[ENT_VALID] = 1'b1;
              ent_new[ENT_HAS] = ent[ENT_HAS];
              cc_table[idx] = ent_new;
            end
          end else r.status = ST_AWAIT;
          if (r.status == ST_NEW || r.status == ST_CONT) begin
            af_wait = hdr[5];
            pay_mode = PM_PREFIX;
            settle_prefix();
          end
          predicted_results.push_back(r);
        end
      end else begin
        case (pay_mode)
          PM_PREFIX: begin
            if (af_wait) begin
              skip_cnt = b;
              af_wait = 1'b0;
            end else if (skip_cnt != 0) begin
              skip_cnt--;
            end else if (ptr_wait) begin
              ptr_cnt = b;
              ptr_wait = 1'b0;
            end
            settle_prefix();
          end
          PM_POINTER: begin
            // Bytes before the new section close the previous one, if it had data.
            ptr_cnt--;
            if (ptr_cnt == 0) pay_mode = PM_FORWARD;
            if (prev_data) begin
              r.result_kind = KIND_PAY;
              r.packet_id = pid;
              r.payload_byte = b;
              r.to_previous = 1'b1;
              r.last = last_b;
              predicted_results.push_back(r);
            end
          end
          PM_FORWARD: begin
            cc_table[idx][ENT_HAS] = 1'b1;
            r.result_kind = KIND_PAY;
            r.packet_id = pid;
            r.payload_byte = b;
            r.section_start = start_wait;
            r.last = last_b;
            start_wait = 1'b0;
            predicted_results.push_back(r);
          end
          default: ;
        endcase
      end
      if (last_b) begin
        locked = 1'b0;
        pkt_pos = 0;
        pay_mode = PM_NONE;
      end else begin
        pkt_pos = pos + 1;
      end
    end
  endtask

  // Idle length for either side: mostly short, a few long, with calm stretches.
  function automatic int idle_len(inout bit calm);
    int roll;
    if ($urandom_range(0, 199) == 0) calm = !calm;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, MAX_IDLE);
  endfunction

  // Length for an adaptation field or a pointer field, sometimes past the packet end.
  function automatic int rand_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(0, 15);
    if (roll < 90) return $urandom_range(16, 150);
    if (roll < 97) return $urandom_range(151, 183);
    return $urandom_range(184, 255);
  endfunction

  // Queues one packet, or its first len bytes, with random payload content.
  task automatic add_packet(input bit tei, input bit pusi, input bit prio,
                            input logic [12:0] pid, input logic [1:0] tsc,
                            input logic [1:0] afc, input logic [3:0] cc,
                            input int af_len, input int ptr, input int len);
    logic [7:0] pkt[PKT];
    int         p;
    for (int i = 4; i < PKT; i++) pkt[i] = 8'($urandom);
    pkt[0] = SYNC_BYTE;
    pkt[1] = {tei, pusi, prio, pid[12:8]};
    pkt[2] = pid[7:0];
    pkt[3] = {tsc, afc, cc};
    p = 4;
    if (afc[1]) begin
      pkt[p] = 8'(af_len);
      p = p + 1 + af_len;
    end
    if (afc[0] && pusi && p < PKT) pkt[p] = 8'(ptr);
    for (int i = 0; i < len; i++) ts_bytes.push_back(pkt[i]);
  endtask

  task automatic add_noise(input int n, input bit allow_sync);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      do b = 8'($urandom); while (!allow_sync && b == SYNC_BYTE);
      ts_bytes.push_back(b);
    end
  endtask

  // Driver: presents queued bytes with random gaps and holds them while stalled.
  int gap_left = 0;
  bit in_calm = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) demux_step(in_stream_byte);
      if (in_valid && in_stall) begin
        in_valid <= 1'b1;
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (ts_bytes.size() != 0) begin
        in_valid <= 1'b1;
        in_stream_byte <= ts_bytes.pop_front();
        gap_left = idle_len(in_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Monitor: checks each result transaction against the oldest prediction.
  int   stall_left = 0;
  bit   out_calm = 1'b0;
  res_t seen;
  res_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        seen = {out_result_kind, out_status, out_packet_id, out_discontinuity,
                out_counter_gap, out_dropped_bytes, out_payload_byte,
                out_to_previous, out_section_start, out_last};
        if (predicted_results.size() == 0) begin
          $display("%0t: unexpected result transaction, expected none actual %h",
                   $time, seen);
          mismatch_count++;
        end else begin
          want = predicted_results.pop_front();
          compare_field("result_kind", 16'(want.result_kind), 16'(seen.result_kind));
          compare_field("status", 16'(want.status), 16'(seen.status));
          compare_field("packet_id", 16'(want.packet_id), 16'(seen.packet_id));
          compare_field("discontinuity", 16'(want.discontinuity),
                        16'(seen.discontinuity));
          compare_field("counter_gap", 16'(want.counter_gap), 16'(seen.counter_gap));
          compare_field("dropped_bytes", want.dropped_bytes, seen.dropped_bytes);
          compare_field("payload_byte", 16'(want.payload_byte), 16'(seen.payload_byte));
          compare_field("to_previous", 16'(want.to_previous), 16'(seen.to_previous));
          compare_field("section_start", 16'(want.section_start),
                        16'(seen.section_start));
          compare_field("last", 16'(want.last), 16'(seen.last));
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 3) == 0) stall_left = idle_len(out_calm);
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("%0t: timeout, %0d results still outstanding", $time,
               predicted_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [12:0] pid;
    logic [3:0]  cc;
    logic [1:0]  afc;
    bit          pusi;
    int          roll;

    // A little noise, then a new section on one PID.
    pid = 13'($urandom_range(1, 8191));
    cc  = 4'($urandom);
    afc = ($urandom_range(0, 9) < 7) ? 2'b01 : 2'b11;
    add_noise($urandom_range(1, 6), 0);
    add_packet(0, 1, 1'($urandom), pid, 2'b00, afc, cc, rand_len(), rand_len(), PKT);

    // Next packet on the same PID: in order, repeated, out of order or a new start.
    roll = $urandom_range(0, 99);
    pusi = 1'b0;
    if (roll < 55) cc = cc + 4'd1;
    else if (roll < 85) begin
      if (roll >= 70) cc = 4'($urandom);
    end else pusi = 1'b1;
    afc = ($urandom_range(0, 9) < 7) ? 2'b01 : 2'b11;
    add_packet(0, pusi, 1'($urandom), pid, 2'b00, afc, cc, rand_len(), rand_len(), PKT);

    // A stray byte may cost sync; then the start of a third packet, cut short.
    add_noise($urandom_range(0, 1), 0);
    roll = $urandom_range(0, 5);
    case (roll)
      0: add_packet(1, 1'($urandom), 1'($urandom), 13'($urandom), 2'($urandom),
                    2'($urandom), 4'($urandom), rand_len(), rand_len(), 24);
      1: add_packet(0, 1'($urandom), 1'($urandom), pid, 2'($urandom_range(1, 3)),
                    2'b01, 4'($urandom), 0, rand_len(), 24);
      2: add_packet(0, 1'($urandom), 1'($urandom), 13'h000, 2'b00, 2'b11,
                    4'($urandom), rand_len(), rand_len(), 24);
      3: add_packet(0, 1'($urandom), 1'($urandom), pid, 2'b00,
                    {1'($urandom), 1'b0}, 4'($urandom), rand_len(), 0, 24);
      4: add_packet(0, 0, 1'($urandom), 13'($urandom_range(1, 8191)), 2'b00,
                    2'b01, 4'($urandom), 0, 0, 24);
      default: add_packet(0, 0, 1'($urandom), pid, 2'b00, 2'b01, cc + 4'd1, 0, 0, 24);
    endcase

    // Slowest legal pace: every byte waits out the longest gap and the longest stall.
    cycle_limit = 4 * (PIDS + 1000 + longint'(ts_bytes.size()) * (2 * MAX_IDLE + 4));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (ts_bytes.size() != 0 || in_valid) @(posedge clk);
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (32) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/tsdmx_pkg.sv
hw/rtl/ts_packet_demux_cc_check.sv
verif/tb_ts_packet_demux_cc_check.sv
